// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker modules of the sensor indicator.
// Each macro wraps one clocked concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that an enabling condition implies prop in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// Checks that an enabling condition implies prop in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/shai_pkg.sv -----
// Package of the sensor hold and alarm indicator: types, register indexes and constants.
// Used by every module of the block; depends on nothing.
package shai_pkg;

    // Width of the tick counter, the trigger times and the blinker deadlines.
    localparam int TIME_BITS      = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_LED_MODE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUZZER_MODE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_MS     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_MS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW_GAP_MS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_GAP_MS = 3'd5;

    // Reset values of the duration registers.
    localparam logic [15:0] HOLD_RESET  = 16'd5000;
    localparam logic [15:0] PULSE_RESET = 16'd100;
    localparam logic [15:0] SLOW_RESET  = 16'd2000;
    localparam logic [15:0] FAST_RESET  = 16'd500;

    // Controller state codes carried by each tick.
    localparam logic [1:0] CTRL_IDLE  = 2'd0;
    localparam logic [1:0] CTRL_ARMED = 2'd1;
    localparam logic [1:0] CTRL_TEMPO = 2'd2;
    localparam logic [1:0] CTRL_ALARM = 2'd3;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [1:0]  led_mode;
        logic [1:0]  buzzer_mode;
        logic [15:0] hold_ms;
        logic [15:0] pulse_ms;
        logic [15:0] slow_gap_ms;
        logic [15:0] fast_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] controller_state;
        logic       vibration_level;
        logic       movement_level;
        logic       vibration_trigger;
        logic       movement_trigger;
    } t_item;

    typedef struct packed {
        logic       buzzer_on;
        logic       led_on;
        logic       report_change;
        logic [1:0] sensor_flags;
    } t_result;

    // Action requested from a blinker in one tick; neither bit set means hold.
    typedef struct packed {
        logic run;
        logic stop;
    } t_blk_ctrl;

endpackage

// ----- hdl/shai_cfg.sv -----
// Configuration register file of the sensor indicator.
// Depends on shai_pkg for the register indexes, reset values and the t_cfg bundle.
module shai_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [shai_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [shai_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output shai_pkg::t_cfg                    o_cfg
);

    shai_pkg::t_cfg r_cfg;

    // Registers take a write at once; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_mode    <= 2'd0;
            r_cfg.buzzer_mode <= 2'd0;
            r_cfg.hold_ms     <= shai_pkg::HOLD_RESET;
            r_cfg.pulse_ms    <= shai_pkg::PULSE_RESET;
            r_cfg.slow_gap_ms <= shai_pkg::SLOW_RESET;
            r_cfg.fast_gap_ms <= shai_pkg::FAST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                shai_pkg::CFG_LED_MODE:    r_cfg.led_mode    <= i_cfg_data[1:0];
                shai_pkg::CFG_BUZZER_MODE: r_cfg.buzzer_mode <= i_cfg_data[1:0];
                shai_pkg::CFG_HOLD_MS:     r_cfg.hold_ms     <= i_cfg_data;
                shai_pkg::CFG_PULSE_MS:    r_cfg.pulse_ms    <= i_cfg_data;
                shai_pkg::CFG_SLOW_GAP_MS: r_cfg.slow_gap_ms <= i_cfg_data;
                shai_pkg::CFG_FAST_GAP_MS: r_cfg.fast_gap_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/shai_blinker.sv -----
// On/off blinker with a free deadline, used for the LED and the buzzer.
// Depends on shai_pkg for the time type and the t_blk_ctrl action bundle.
module shai_blinker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  shai_pkg::t_blk_ctrl i_ctrl,
    input  shai_pkg::t_time     i_now,
    input  logic [15:0]         i_on_ms,
    input  logic [15:0]         i_off_ms,
    output logic                o_phase
);

    logic            r_running;
    logic            r_phase;
    shai_pkg::t_time r_deadline;
    logic            n_running;
    logic            n_phase;
    shai_pkg::t_time n_deadline;

    // Start goes on at once; afterwards the phase toggles after each deadline passes.
    always_comb begin
        n_running  = r_running;
        n_phase    = r_phase;
        n_deadline = r_deadline;
        priority if (i_ctrl.stop) begin
            n_running  = 1'b0;
            n_phase    = 1'b0;
            n_deadline = '0;
        end else if (i_ctrl.run) begin
            if (!r_running) begin
                n_running  = 1'b1;
                n_phase    = 1'b1;
                n_deadline = i_now + shai_pkg::t_time'(i_on_ms);
            end else if (i_now > r_deadline) begin
                if (r_phase) begin
                    n_phase    = 1'b0;
                    n_deadline = i_now + shai_pkg::t_time'(i_off_ms);
                end else begin
                    n_phase    = 1'b1;
                    n_deadline = i_now + shai_pkg::t_time'(i_on_ms);
                end
            end
        end else begin
            // Neither action: phase and deadline are held as they are.
        end
    end

    // State moves only on a tick that is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_phase    <= 1'b0;
            r_deadline <= '0;
        end else if (i_step) begin
            r_running  <= n_running;
            r_phase    <= n_phase;
            r_deadline <= n_deadline;
        end
    end

    // The phase after this tick's action; a stopped blinker reads as off.
    assign o_phase = n_phase;

endmodule

// ----- hdl/shai_core.sv -----
// Per-tick logic: flag latching, hold timeout, change report, LED and buzzer control.
// Depends on shai_pkg and instantiates two shai_blinker units.
module shai_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  shai_pkg::t_cfg    i_cfg,
    input  shai_pkg::t_item   i_item,
    output shai_pkg::t_result o_result
);

    shai_pkg::t_time     r_now;
    logic [1:0]          r_flags;
    logic [1:0]          r_reported;
    shai_pkg::t_time     r_mov_time;
    shai_pkg::t_time     r_vib_time;

    logic [1:0]          w_latched;
    shai_pkg::t_time     w_mov_time;
    shai_pkg::t_time     w_vib_time;
    logic                w_mov_clear;
    logic                w_vib_clear;
    logic [1:0]          n_flags;
    shai_pkg::t_time     n_mov_time;
    shai_pkg::t_time     n_vib_time;
    logic                w_steady;
    logic                w_led_blink;
    logic                w_alarm_beep;
    logic                w_tempo_beep;
    logic [15:0]         w_buzz_gap;
    shai_pkg::t_blk_ctrl w_led_ctrl;
    shai_pkg::t_blk_ctrl w_buzz_ctrl;
    logic                w_led_phase;
    logic                w_buzz_phase;

    // Triggers latch first and renew the time stamp; the hold check then sees it.
    always_comb begin
        w_latched  = r_flags | {i_item.vibration_trigger, i_item.movement_trigger};
        w_mov_time = i_item.movement_trigger ? r_now : r_mov_time;
        w_vib_time = i_item.vibration_trigger ? r_now : r_vib_time;
        w_mov_clear = w_latched[0] && !i_item.movement_level
                      && ((r_now - w_mov_time) > shai_pkg::t_time'(i_cfg.hold_ms));
        w_vib_clear = w_latched[1] && !i_item.vibration_level
                      && ((r_now - w_vib_time) > shai_pkg::t_time'(i_cfg.hold_ms));
        n_flags    = w_latched & ~{w_vib_clear, w_mov_clear};
        n_mov_time = w_mov_clear ? '0 : w_mov_time;
        n_vib_time = w_vib_clear ? '0 : w_vib_time;
    end

    // LED: steady on detection wins and leaves the blinker untouched.
    always_comb begin
        w_steady        = (n_flags != 2'd0) && i_cfg.led_mode[0];
        w_led_blink     = (i_item.controller_state != shai_pkg::CTRL_IDLE)
                          && i_cfg.led_mode[1];
        w_led_ctrl.run  = !w_steady && w_led_blink;
        w_led_ctrl.stop = !w_steady && !w_led_blink;
    end

    // Buzzer: fast beep in alarm, slow beep in tempo, silent otherwise.
    always_comb begin
        w_alarm_beep     = (i_item.controller_state == shai_pkg::CTRL_ALARM)
                           && i_cfg.buzzer_mode[1];
        w_tempo_beep     = (i_item.controller_state == shai_pkg::CTRL_TEMPO)
                           && i_cfg.buzzer_mode[0];
        w_buzz_gap       = w_alarm_beep ? i_cfg.fast_gap_ms : i_cfg.slow_gap_ms;
        w_buzz_ctrl.run  = w_alarm_beep || w_tempo_beep;
        w_buzz_ctrl.stop = !(w_alarm_beep || w_tempo_beep);
    end

    shai_blinker u_led_blk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (i_step),
        .i_ctrl   (w_led_ctrl),
        .i_now    (r_now),
        .i_on_ms  (i_cfg.pulse_ms),
        .i_off_ms (i_cfg.slow_gap_ms),
        .o_phase  (w_led_phase)
    );

    shai_blinker u_buzz_blk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (i_step),
        .i_ctrl   (w_buzz_ctrl),
        .i_now    (r_now),
        .i_on_ms  (i_cfg.pulse_ms),
        .i_off_ms (w_buzz_gap),
        .o_phase  (w_buzz_phase)
    );

    // Tick state; the reported flags always follow the latched flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_flags    <= 2'd0;
            r_reported <= 2'd0;
            r_mov_time <= '0;
            r_vib_time <= '0;
        end else if (i_step) begin
            r_now      <= r_now + shai_pkg::t_time'(1);
            r_flags    <= n_flags;
            r_reported <= n_flags;
            r_mov_time <= n_mov_time;
            r_vib_time <= n_vib_time;
        end
    end

    // Result of this tick.
    always_comb begin
        o_result.sensor_flags  = n_flags;
        o_result.report_change = (n_flags != r_reported);
        o_result.led_on        = w_steady || (w_led_ctrl.run && w_led_phase);
        o_result.buzzer_on     = w_buzz_phase;
    end

endmodule

// ----- hdl/sensor_hold_and_alarm_indicator_unit.sv -----
// Top level of the sensor hold and alarm indicator: stream ports, input and result registers.
// Depends on shai_pkg, shai_cfg and shai_core.
//
//  Channel   Direction  Beat content
//  s_axis    in         one millisecond tick: triggers, pin levels, controller state
//  m_axis    out        one result per tick: flags, report pulse, LED, buzzer
//  i_cfg_*   in         register write, index 0..5, taken at once
//
// Each tick passes through the input register, then through the core logic into the
// result register. One tick is accepted every cycle while m_axis takes each result.
// Reset is synchronous and active low; it clears the tick counter, flags and blinkers.
// A stall on m_axis holds the result register and, if both registers are full, s_axis.
module sensor_hold_and_alarm_indicator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: movement_trigger, vibration_trigger, movement_level,
    // vibration_level, controller_state[1:0], two zero bits.
    input  logic [shai_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: sensor_flags[1:0], report_change, led_on, buzzer_on,
    // three zero bits.
    output logic [shai_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [shai_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [shai_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    shai_pkg::t_cfg    w_cfg;
    shai_pkg::t_result w_result;
    logic              r_in_valid;
    shai_pkg::t_item   r_in;
    logic              r_out_valid;
    shai_pkg::t_result r_out;
    logic              w_out_free;
    logic              w_step;
    logic              w_in_beat;

    shai_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    shai_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // The core steps whenever a tick waits and the result register can take it.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;

    // Valid flags of the two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_beat) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_in <= shai_pkg::t_item'(s_axis_tdata[5:0]);
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

// ----- hdl/shai_checker.sv -----
// Port-level checker of the sensor indicator, bound to the top level.
// Depends on assert_macros.svh and shai_pkg.
`include "assert_macros.svh"

module shai_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [shai_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

    logic [1:0] r_last_flags;
    logic       w_out_beat;
    logic       w_out_stall;
    logic [1:0] w_flags;
    logic       w_report;
    logic       w_changed;
    logic [2:0] w_pad;

    assign w_out_beat  = m_axis_tvalid && m_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_flags     = m_axis_tdata[1:0];
    assign w_report    = m_axis_tdata[2];
    assign w_pad       = m_axis_tdata[7:5];
    assign w_changed   = (w_flags != r_last_flags);

    // Flags of the last delivered result, as the report pulse compares against.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_flags <= 2'd0;
        end else if (w_out_beat) begin
            r_last_flags <= w_flags;
        end
    end

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid, "result dropped")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_stall, $stable(m_axis_tdata), "data moved")

    // Padding bits of a result are zero.
    `ASSERT_IMPL(a_out_pad, i_clk, i_rst_n, m_axis_tvalid, w_pad == 3'b000, "nonzero padding")

    // The report pulse marks exactly a change of flags between delivered results.
    `ASSERT_IMPL(a_report, i_clk, i_rst_n, w_out_beat, w_report == w_changed, "bad report")

    // With the result register empty the input side is always ready.
    `ASSERT_CLK(a_in_ready, i_clk, i_rst_n, m_axis_tvalid || s_axis_tready, "input not ready")

endmodule

bind sensor_hold_and_alarm_indicator_unit shai_checker u_shai_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sensor_hold_and_alarm_indicator_unit_tb.sv -----
// Self-checking testbench of the sensor hold and alarm indicator: directed and random ticks.
// Predicts each result beat in a behavioral model of the block; depends on shai_pkg and the RTL.
// Sender and receiver idle at random in several phases; a watchdog ends a stuck run.
module sensor_hold_and_alarm_indicator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RESET_CYCLES   = 12;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [shai_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [shai_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic            running;
        logic            phase;
        shai_pkg::t_time deadline;
    } t_blinker;

    localparam t_blinker BLINK_STOPPED = '0;

    // Block ports, all driven from time zero.
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [shai_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [shai_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                                i_cfg_we      = 1'b0;
    logic [shai_pkg::CFG_IDX_BITS-1:0]   i_cfg_index   = '0;
    logic [shai_pkg::CFG_DATA_BITS-1:0]  i_cfg_data    = '0;

    // Model state of the indicator, as it stands after reset.
    shai_pkg::t_cfg  cfg_model   = {2'b00, 2'b00, shai_pkg::HOLD_RESET, shai_pkg::PULSE_RESET,
                                    shai_pkg::SLOW_RESET, shai_pkg::FAST_RESET};
    shai_pkg::t_time tick_now    = '0;
    logic [1:0]      flags_held  = '0;
    logic [1:0]      flags_told  = '0;
    shai_pkg::t_time move_stamp  = '0;
    shai_pkg::t_time vib_stamp   = '0;
    t_blinker        led_blk     = BLINK_STOPPED;
    t_blinker        buzz_blk    = BLINK_STOPPED;

    // Results of accepted ticks that have not come out yet, oldest first.
    shai_pkg::t_result indicator_q[$];
    int                mismatch_count  = 0;
    int                sender_idle_pct = 0;
    int                sink_stall_pct  = 0;

    sensor_hold_and_alarm_indicator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // One blinker step: start on at once, then toggle once the deadline has passed.
    function automatic t_blinker blink_step(t_blinker b, shai_pkg::t_time now,
                                            logic [15:0] on_t, logic [15:0] off_t);
        t_blinker n;
        n = b;
        if (!b.running) begin
            n.running  = 1'b1;
            n.phase    = 1'b1;
            n.deadline = now + shai_pkg::t_time'(on_t);
        end else if (now > b.deadline) begin
            n.phase    = ~b.phase;
            n.deadline = now + shai_pkg::t_time'(b.phase ? off_t : on_t);
        end
        return n;
    endfunction

    // Advances the model by one tick and returns the result beat it produces.
    function automatic shai_pkg::t_result indicator_tick(shai_pkg::t_item it);
        shai_pkg::t_result r;
        shai_pkg::t_time   now;
        now = tick_now;
        r   = '0;

        // Triggers latch first and stamp the time, also on a flag already set.
        if (it.movement_trigger) begin
            flags_held[0] = 1'b1;
            move_stamp    = now;
        end
        if (it.vibration_trigger) begin
            flags_held[1] = 1'b1;
            vib_stamp     = now;
        end

        // A flag clears once the hold time has passed and its pin is released.
        if (flags_held[0]
            && (shai_pkg::t_time'(now - move_stamp) > shai_pkg::t_time'(cfg_model.hold_ms))
            && !it.movement_level) begin
            flags_held[0] = 1'b0;
            move_stamp    = '0;
        end
        if (flags_held[1]
            && (shai_pkg::t_time'(now - vib_stamp) > shai_pkg::t_time'(cfg_model.hold_ms))
            && !it.vibration_level) begin
            flags_held[1] = 1'b0;
            vib_stamp     = '0;
        end

        if (flags_held != flags_told) begin
            flags_told      = flags_held;
            r.report_change = 1'b1;
        end

        // Steady LED takes priority and leaves the blinker untouched.
        if (flags_held != 2'b00 && cfg_model.led_mode[0]) begin
            r.led_on = 1'b1;
        end else if (it.controller_state != shai_pkg::CTRL_IDLE
                     && cfg_model.led_mode[1]) begin
            led_blk  = blink_step(led_blk, now, cfg_model.pulse_ms, cfg_model.slow_gap_ms);
            r.led_on = led_blk.phase;
        end else begin
            led_blk  = BLINK_STOPPED;
            r.led_on = 1'b0;
        end

        if (it.controller_state == shai_pkg::CTRL_ALARM && cfg_model.buzzer_mode[1]) begin
            buzz_blk = blink_step(buzz_blk, now, cfg_model.pulse_ms, cfg_model.fast_gap_ms);
        end else if (it.controller_state == shai_pkg::CTRL_TEMPO
                     && cfg_model.buzzer_mode[0]) begin
            buzz_blk = blink_step(buzz_blk, now, cfg_model.pulse_ms, cfg_model.slow_gap_ms);
        end else begin
            buzz_blk = BLINK_STOPPED;
        end

        r.sensor_flags = flags_held;
        r.buzzer_on    = buzz_blk.running & buzz_blk.phase;
        tick_now       = now + shai_pkg::t_time'(1);
        return r;
    endfunction

    function automatic shai_pkg::t_item make_item(logic mt, logic vt, logic ml, logic vl,
                                                  logic [1:0] ctrl);
        shai_pkg::t_item it;
        it.movement_trigger  = mt;
        it.vibration_trigger = vt;
        it.movement_level    = ml;
        it.vibration_level   = vl;
        it.controller_state  = ctrl;
        return it;
    endfunction

    // Writes one register while the block is idle and mirrors it in the model.
    task automatic write_reg(logic [shai_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [shai_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            shai_pkg::CFG_LED_MODE:    cfg_model.led_mode    = data[1:0];
            shai_pkg::CFG_BUZZER_MODE: cfg_model.buzzer_mode = data[1:0];
            shai_pkg::CFG_HOLD_MS:     cfg_model.hold_ms     = data;
            shai_pkg::CFG_PULSE_MS:    cfg_model.pulse_ms    = data;
            shai_pkg::CFG_SLOW_GAP_MS: cfg_model.slow_gap_ms = data;
            shai_pkg::CFG_FAST_GAP_MS: cfg_model.fast_gap_ms = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic [15:0] led, logic [15:0] buzz, logic [15:0] hold,
                                  logic [15:0] pulse, logic [15:0] slow, logic [15:0] fast);
        write_reg(shai_pkg::CFG_LED_MODE, led);
        write_reg(shai_pkg::CFG_BUZZER_MODE, buzz);
        write_reg(shai_pkg::CFG_HOLD_MS, hold);
        write_reg(shai_pkg::CFG_PULSE_MS, pulse);
        write_reg(shai_pkg::CFG_SLOW_GAP_MS, slow);
        write_reg(shai_pkg::CFG_FAST_GAP_MS, fast);
    endtask

    // Sends one tick beat, records its predicted result, then maybe idles a while.
    task automatic send_tick(shai_pkg::t_item it);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        indicator_q.push_back(indicator_tick(it));
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 200) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every pending result has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (indicator_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Reset values: flags latch and report, LED and buzzer stay off.
    task automatic test_reset_defaults();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_IDLE));
        send_tick(make_item(1'b1, 1'b0, 1'b1, 1'b0, shai_pkg::CTRL_ALARM));
        send_tick(make_item(1'b0, 1'b1, 1'b0, 1'b1, shai_pkg::CTRL_TEMPO));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_ARMED));
        wait_idle();
    endtask

    // Short hold and blink times: steady LED over a held blinker, renewed triggers,
    // flag release by pin level, tempo to alarm switch, zero gap.
    task automatic test_flag_hold_and_blink();
        write_all_regs(16'd3, 16'd3, 16'd2, 16'd1, 16'd2, 16'd0);
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_ARMED));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_ARMED));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_ARMED));
        send_tick(make_item(1'b1, 1'b0, 1'b1, 1'b0, shai_pkg::CTRL_ARMED));
        send_tick(make_item(1'b1, 1'b0, 1'b1, 1'b0, shai_pkg::CTRL_TEMPO));
        send_tick(make_item(1'b0, 1'b1, 1'b1, 1'b1, shai_pkg::CTRL_ALARM));
        send_tick(make_item(1'b0, 1'b0, 1'b1, 1'b0, shai_pkg::CTRL_ALARM));
        send_tick(make_item(1'b0, 1'b0, 1'b1, 1'b0, shai_pkg::CTRL_ALARM));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_ALARM));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_TEMPO));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_TEMPO));
        send_tick(make_item(1'b1, 1'b1, 1'b0, 1'b0, shai_pkg::CTRL_IDLE));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_IDLE));
        wait_idle();
    endtask

    // Largest and zero durations, plus writes to the unused indexes.
    task automatic test_extreme_durations();
        write_all_regs(16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'hAAAA);
        send_tick(make_item(1'b1, 1'b1, 1'b0, 1'b0, shai_pkg::CTRL_ALARM));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_ARMED));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_ALARM));
        wait_idle();
        write_all_regs(16'h5554, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(make_item(1'b1, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_TEMPO));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_TEMPO));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_TEMPO));
        send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, shai_pkg::CTRL_TEMPO));
        wait_idle();
    endtask

    // New random settings; durations mostly short so flags and blinkers keep moving.
    task automatic randomize_config();
        logic [15:0] hold, pulse, slow, fast;
        hold  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        pulse = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(8));
        slow  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(15));
        fast  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
        write_all_regs(16'($urandom), 16'($urandom), hold, pulse, slow, fast);
        write_reg($urandom_range(1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, 16'($urandom));
    endtask

    // Controller state and pin levels persist over runs of ticks, triggers are sparse;
    // about one tick in ten is pure noise.
    task automatic run_random_phase(int n_ticks, int idle_pct, int stall_pct);
        logic [1:0]      ctrl;
        logic            mlvl, vlvl;
        shai_pkg::t_item it;
        ctrl = 2'($urandom_range(3));
        mlvl = 1'b0;
        vlvl = 1'b0;
        randomize_config();
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        repeat (n_ticks) begin
            if ($urandom_range(9) == 0) begin
                it = shai_pkg::t_item'(6'($urandom));
            end else begin
                if ($urandom_range(19) == 0) ctrl = 2'($urandom_range(3));
                if ($urandom_range(9) == 0) mlvl = ~mlvl;
                if ($urandom_range(9) == 0) vlvl = ~vlvl;
                it = make_item($urandom_range(99) < 8, $urandom_range(99) < 8, mlvl, vlvl,
                               ctrl);
            end
            send_tick(it);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(220, 0, 0);
        run_random_phase(220, 74, 0);
        run_random_phase(220, 0, 74);
        run_random_phase(220, 31, 31);
        run_random_phase(220, 0, 0);
    endtask

    // Result side: compare each accepted beat with the oldest prediction, then pick
    // the next ready level.
    always @(posedge i_clk) begin : result_sink
        shai_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got = shai_pkg::t_result'(m_axis_tdata[4:0]);
            if (indicator_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with no tick pending, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = indicator_q.pop_front();
                if (got.sensor_flags !== want.sensor_flags) begin
                    mismatch_count++;
                    $display("%0t: sensor_flags expected %b actual %b",
                             $time, want.sensor_flags, got.sensor_flags);
                end
                if (got.report_change !== want.report_change) begin
                    mismatch_count++;
                    $display("%0t: report_change expected %b actual %b",
                             $time, want.report_change, got.report_change);
                end
                if (got.led_on !== want.led_on) begin
                    mismatch_count++;
                    $display("%0t: led_on expected %b actual %b",
                             $time, want.led_on, got.led_on);
                end
                if (got.buzzer_on !== want.buzzer_on) begin
                    mismatch_count++;
                    $display("%0t: buzzer_on expected %b actual %b",
                             $time, want.buzzer_on, got.buzzer_on);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Ends the run when no beat has moved on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready === 1'b1)
                || (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Reset once, then the tests in turn.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_flag_hold_and_blink();
        test_extreme_durations();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
